/* rtl/dmsc_pkg.sv */
// ----------------------------------------------------------------------------
// dmsc_pkg
// Shared types and constants of the delta modulation sample channel.
// ----------------------------------------------------------------------------
package dmsc_pkg;

   // request function codes
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_START = 2'd1,
      FUNC_STOP  = 2'd2
   } dmsc_func_type;

   // configuration register indexes (byte address = 4 * index)
   typedef enum logic [2:0] {
      REG_PERIOD_RELOAD  = 3'd0,
      REG_LOOP_MODE      = 3'd1,
      REG_IRQ_ENABLE     = 3'd2,
      REG_SAMPLE_ADDRESS = 3'd3,
      REG_SAMPLE_LENGTH  = 3'd4
   } dmsc_reg_type;

   localparam logic [14:0] ADDR_BASE        = 15'h4000;
   localparam logic        DMA_HIGH_BIT     = 1'b1;
   localparam logic [2:0]  FETCH_DELAY_LOAD = 3'd4;
   localparam logic [9:0]  PERIOD_RESET     = 10'd428;

   typedef struct packed {
      logic [9:0] period_reload;
      logic       loop_mode;
      logic       irq_enable;
      logic [7:0] sample_address;
      logic [7:0] sample_length;
   } dmsc_cfg_type;

   typedef struct packed {
      logic [6:0]  dac_level;
      logic [7:0]  shift_byte;
      logic        shift_full;
      logic [2:0]  bit_index;
      logic [7:0]  buffer_byte;
      logic        buffer_full;
      logic [14:0] fetch_address;
      logic [11:0] bytes_left;
      logic [9:0]  period_count;
      logic [2:0]  fetch_delay;
      logic        halt_line;
      logic        addr_driven;
      logic        irq_flag;
   } dmsc_state_type;

   typedef struct packed {
      logic [6:0]  level_out;
      logic        cpu_halt;
      logic        dma_valid;
      logic [15:0] dma_address;
      logic        irq_out;
   } dmsc_result_type;

endpackage

/* rtl/dmsc_step.sv */
// ----------------------------------------------------------------------------
// dmsc_step
// Next-state and result logic for one request of the sample channel.
// ----------------------------------------------------------------------------
module dmsc_step (
   input  dmsc_pkg::dmsc_cfg_type    cfg,
   input  dmsc_pkg::dmsc_state_type  cur,
   input  logic [1:0]                func,
   input  logic [7:0]                mem_data,
   output dmsc_pkg::dmsc_state_type  nxt,
   output dmsc_pkg::dmsc_result_type res
);

   logic [14:0] start_address;
   logic [11:0] start_count;
   logic [7:0]  level_step;
   logic        bit_up;

   assign start_address = dmsc_pkg::ADDR_BASE + {1'b0, cfg.sample_address, 6'b0};
   assign start_count   = {cfg.sample_length, 4'b0} + 12'd1;

   always_comb begin
      nxt        = cur;
      bit_up     = 1'b0;
      level_step = 8'd0;
      case (dmsc_pkg::dmsc_func_type'(func))
         dmsc_pkg::FUNC_TICK: begin
            // DMA delay countdown
            if (cur.fetch_delay != 3'd0) begin
               nxt.fetch_delay = cur.fetch_delay - 3'd1;
               if (nxt.fetch_delay == 3'd1) begin
                  nxt.addr_driven = 1'b1;
               end else if (nxt.fetch_delay == 3'd0) begin
                  nxt.halt_line     = 1'b0;
                  nxt.addr_driven   = 1'b0;
                  nxt.buffer_byte   = mem_data;
                  nxt.buffer_full   = 1'b1;
                  nxt.bytes_left    = cur.bytes_left - 12'd1;
                  nxt.fetch_address = cur.fetch_address + 15'd1;
                  if (nxt.bytes_left == 12'd0) begin
                     if (cfg.loop_mode) begin
                        nxt.fetch_address = start_address;
                        nxt.bytes_left    = start_count;
                     end else if (cfg.irq_enable) begin
                        nxt.irq_flag = 1'b1;
                     end
                  end
               end
            end
            // output timer
            nxt.period_count = cur.period_count - 10'd1;
            if (nxt.period_count == 10'd0) begin
               bit_up     = cur.shift_byte[cur.bit_index];
               level_step = bit_up ? {1'b0, cur.dac_level} + 8'd2
                                   : {1'b0, cur.dac_level} - 8'd2;
               // hold the level where a step would leave 0..127
               if (cur.shift_full && !level_step[7]) begin
                  nxt.dac_level = level_step[6:0];
               end
               nxt.bit_index = cur.bit_index + 3'd1;
               if (nxt.bit_index == 3'd0) begin
                  if (nxt.buffer_full) begin
                     nxt.shift_full  = 1'b1;
                     nxt.shift_byte  = nxt.buffer_byte;
                     nxt.buffer_full = 1'b0;
                  end else begin
                     nxt.shift_full = 1'b0;
                  end
               end
               nxt.period_count = cfg.period_reload;
            end
            // request the next fetch
            if (nxt.bytes_left != 12'd0 && !nxt.buffer_full &&
                nxt.fetch_delay == 3'd0) begin
               nxt.halt_line   = 1'b1;
               nxt.fetch_delay = dmsc_pkg::FETCH_DELAY_LOAD;
            end
         end
         dmsc_pkg::FUNC_START: begin
            if (cur.bytes_left == 12'd0) begin
               nxt.fetch_address = start_address;
               nxt.bytes_left    = start_count;
            end
         end
         dmsc_pkg::FUNC_STOP: begin
            nxt.bytes_left  = 12'd0;
            nxt.fetch_delay = 3'd0;
            nxt.halt_line   = 1'b0;
            nxt.addr_driven = 1'b0;
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   always_comb begin
      res.level_out   = cur.dac_level;
      res.cpu_halt    = nxt.halt_line;
      res.dma_valid   = nxt.addr_driven;
      res.dma_address = nxt.addr_driven ? {dmsc_pkg::DMA_HIGH_BIT, nxt.fetch_address}
                                        : 16'd0;
      res.irq_out     = nxt.irq_flag;
   end

endmodule

/* rtl/delta_modulation_sample_channel.sv */
// ----------------------------------------------------------------------------
// delta_modulation_sample_channel
// Delta modulation sample channel: DMA fetch sequencing, 7-bit level output.
// ----------------------------------------------------------------------------
// Pipeline: each request passes through the request register, then the
//   result register. Throughput: one request per cycle, set by the
//   single-pass step logic, while the result channel is not stalled.
// Reset (synchronous, active high): clears the channel state but loads the
//   timer, restores register defaults (period reload 428); both stages empty.
// ----------------------------------------------------------------------------
module delta_modulation_sample_channel (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_mem_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_level_out,
   output logic        rsp_cpu_halt,
   output logic        rsp_dma_valid,
   output logic [15:0] rsp_dma_address,
   output logic        rsp_irq_out,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // request stage
   logic       in_valid_ff;
   logic [1:0] in_func_ff;
   logic [7:0] in_data_ff;

   // result stage
   logic                      rsp_valid_ff;
   dmsc_pkg::dmsc_result_type rsp_ff;
   dmsc_pkg::dmsc_result_type rsp_in;

   // channel state and configuration
   dmsc_pkg::dmsc_state_type state_ff;
   dmsc_pkg::dmsc_state_type state_in;
   dmsc_pkg::dmsc_state_type state_reset;
   dmsc_pkg::dmsc_cfg_type   cfg_ff;

   logic advance;
   logic cfg_write;

   // Move the held request into the result stage when that stage is free
   // or drains in this cycle; take a new request whenever the request
   // stage empties, so one request can wait behind a stalled result.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_func_ff <= req_func;
         in_data_ff <= req_mem_data;
      end
   end

   dmsc_step u_step (
      .cfg      (cfg_ff),
      .cur      (state_ff),
      .func     (in_func_ff),
      .mem_data (in_data_ff),
      .nxt      (state_in),
      .res      (rsp_in)
   );

   // Reset image of the channel state: all clear except the timer.
   always_comb begin
      state_reset              = '0;
      state_reset.period_count = dmsc_pkg::PERIOD_RESET;
   end

   // Commit the step only when its result is captured.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= state_reset;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level_out   = rsp_ff.level_out;
   assign rsp_cpu_halt    = rsp_ff.cpu_halt;
   assign rsp_dma_valid   = rsp_ff.dma_valid;
   assign rsp_dma_address = rsp_ff.dma_address;
   assign rsp_irq_out     = rsp_ff.irq_out;

   // Configuration: zero-wait APB, write in the access phase. Addresses
   // past the last register are dropped on write and read as zero.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_reload  <= dmsc_pkg::PERIOD_RESET;
         cfg_ff.loop_mode      <= 1'b0;
         cfg_ff.irq_enable     <= 1'b0;
         cfg_ff.sample_address <= 8'd0;
         cfg_ff.sample_length  <= 8'd0;
      end else if (cfg_write) begin
         case (dmsc_pkg::dmsc_reg_type'(paddr[4:2]))
            dmsc_pkg::REG_PERIOD_RELOAD:  cfg_ff.period_reload  <= pwdata[9:0];
            dmsc_pkg::REG_LOOP_MODE:      cfg_ff.loop_mode      <= pwdata[0];
            dmsc_pkg::REG_IRQ_ENABLE:     cfg_ff.irq_enable     <= pwdata[0];
            dmsc_pkg::REG_SAMPLE_ADDRESS: cfg_ff.sample_address <= pwdata[7:0];
            dmsc_pkg::REG_SAMPLE_LENGTH:  cfg_ff.sample_length  <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (dmsc_pkg::dmsc_reg_type'(paddr[4:2]))
         dmsc_pkg::REG_PERIOD_RELOAD:  prdata = {22'd0, cfg_ff.period_reload};
         dmsc_pkg::REG_LOOP_MODE:      prdata = {31'd0, cfg_ff.loop_mode};
         dmsc_pkg::REG_IRQ_ENABLE:     prdata = {31'd0, cfg_ff.irq_enable};
         dmsc_pkg::REG_SAMPLE_ADDRESS: prdata = {24'd0, cfg_ff.sample_address};
         dmsc_pkg::REG_SAMPLE_LENGTH:  prdata = {24'd0, cfg_ff.sample_length};
         default:                      prdata = 32'd0;
      endcase
   end

endmodule

/* test/delta_modulation_sample_channel_test.sv */
// ----------------------------------------------------------------------------
// delta_modulation_sample_channel_test
// Self-checking bench for the delta modulation sample channel. Requests are
// driven on a valid/ready channel with random bursts and gaps, and each
// result is checked field by field against an in-bench model of the channel
// state. Registers are written over the APB-style port between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module delta_modulation_sample_channel_test;

   // function code with no defined meaning
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   // Drive every block input to a known value from time zero.
   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func     = dmsc_pkg::FUNC_TICK;
   logic [7:0]  req_mem_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready    = 1'b0;
   logic [6:0]  rsp_level_out;
   logic        rsp_cpu_halt;
   logic        rsp_dma_valid;
   logic [15:0] rsp_dma_address;
   logic        rsp_irq_out;
   logic        psel         = 1'b0;
   logic        penable      = 1'b0;
   logic        pwrite       = 1'b0;
   logic [4:0]  paddr        = 5'd0;
   logic [31:0] pwdata       = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   // Mirror of the channel: register settings and internal state.
   dmsc_pkg::dmsc_cfg_type    chan_cfg;
   dmsc_pkg::dmsc_state_type  chan_state;
   dmsc_pkg::dmsc_result_type pending_results[$];

   int error_count = 0;
   int burst_left  = 0;
   int ready_mode  = 0;
   int ready_left  = 0;
   int ready_phase = 0;

   delta_modulation_sample_channel u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_mem_data   (req_mem_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level_out  (rsp_level_out),
      .rsp_cpu_halt   (rsp_cpu_halt),
      .rsp_dma_valid  (rsp_dma_valid),
      .rsp_dma_address(rsp_dma_address),
      .rsp_irq_out    (rsp_irq_out),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Channel model
   // ------------------------------------------------------------------

   // Latch the start address and byte count from the sample registers.
   function automatic void load_sample();
      chan_state.fetch_address = dmsc_pkg::ADDR_BASE +
                                 {1'b0, chan_cfg.sample_address, 6'd0};
      chan_state.bytes_left    = {chan_cfg.sample_length, 4'd0} + 12'd1;
   endfunction

   // Advance the channel by one request and return the result it produces.
   function automatic dmsc_pkg::dmsc_result_type predict_channel_step(
         logic [1:0] func, logic [7:0] data);
      dmsc_pkg::dmsc_result_type res;
      logic [6:0]                level_prior;
      logic [7:0]                level_next;

      level_prior = chan_state.dac_level;
      if (func == dmsc_pkg::FUNC_TICK) begin
         // DMA countdown: address at count 1, byte taken at count 0.
         if (chan_state.fetch_delay != 3'd0) begin
            chan_state.fetch_delay = chan_state.fetch_delay - 3'd1;
            if (chan_state.fetch_delay == 3'd1) begin
               chan_state.addr_driven = 1'b1;
            end else if (chan_state.fetch_delay == 3'd0) begin
               chan_state.halt_line     = 1'b0;
               chan_state.addr_driven   = 1'b0;
               chan_state.buffer_byte   = data;
               chan_state.buffer_full   = 1'b1;
               chan_state.bytes_left    = chan_state.bytes_left - 12'd1;
               chan_state.fetch_address = chan_state.fetch_address + 15'd1;
               if (chan_state.bytes_left == 12'd0) begin
                  if (chan_cfg.loop_mode) begin
                     load_sample();
                  end else if (chan_cfg.irq_enable) begin
                     chan_state.irq_flag = 1'b1;
                  end
               end
            end
         end
         // Output timer: one delta bit per expiry, level holds at the rails.
         chan_state.period_count = chan_state.period_count - 10'd1;
         if (chan_state.period_count == 10'd0) begin
            if (chan_state.shift_full) begin
               if (chan_state.shift_byte[chan_state.bit_index]) begin
                  level_next = {1'b0, chan_state.dac_level} + 8'd2;
               end else begin
                  level_next = {1'b0, chan_state.dac_level} - 8'd2;
               end
               if (!level_next[7]) begin
                  chan_state.dac_level = level_next[6:0];
               end
            end
            chan_state.bit_index = chan_state.bit_index + 3'd1;
            if (chan_state.bit_index == 3'd0) begin
               chan_state.shift_full = chan_state.buffer_full;
               if (chan_state.buffer_full) begin
                  chan_state.shift_byte  = chan_state.buffer_byte;
                  chan_state.buffer_full = 1'b0;
               end
            end
            chan_state.period_count = chan_cfg.period_reload;
         end
         // Request the next byte when the buffer is empty.
         if (chan_state.bytes_left != 12'd0 && !chan_state.buffer_full &&
             chan_state.fetch_delay == 3'd0) begin
            chan_state.halt_line   = 1'b1;
            chan_state.fetch_delay = dmsc_pkg::FETCH_DELAY_LOAD;
         end
      end else if (func == dmsc_pkg::FUNC_START) begin
         // Ignore a start while bytes remain.
         if (chan_state.bytes_left == 12'd0) begin
            load_sample();
         end
      end else if (func == dmsc_pkg::FUNC_STOP) begin
         chan_state.bytes_left  = 12'd0;
         chan_state.fetch_delay = 3'd0;
         chan_state.halt_line   = 1'b0;
         chan_state.addr_driven = 1'b0;
      end

      res.level_out   = level_prior;
      res.cpu_halt    = chan_state.halt_line;
      res.dma_valid   = chan_state.addr_driven;
      res.dma_address = chan_state.addr_driven ?
                        {dmsc_pkg::DMA_HIGH_BIT, chan_state.fetch_address} : 16'd0;
      res.irq_out     = chan_state.irq_flag;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Result checker and receiver stall pattern
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input logic [15:0] exp_v,
                              input logic [15:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Compare every accepted result with the oldest prediction.
   always @(posedge clock) begin
      dmsc_pkg::dmsc_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual level %0d",
                     $time, rsp_level_out);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            check_field("level_out", 16'(exp_r.level_out), 16'(rsp_level_out));
            check_field("cpu_halt", 16'(exp_r.cpu_halt), 16'(rsp_cpu_halt));
            check_field("dma_valid", 16'(exp_r.dma_valid), 16'(rsp_dma_valid));
            check_field("dma_address", exp_r.dma_address, rsp_dma_address);
            check_field("irq_out", 16'(exp_r.irq_out), 16'(rsp_irq_out));
         end
      end
   end

   // Receiver: switch among full rate, light stalls, heavy stalls and a
   // periodic stall pattern.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(50, 300);
      end
      ready_left--;
      ready_phase++;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 99) >= 25);
         2: rsp_ready <= ($urandom_range(0, 99) >= 70);
         default: rsp_ready <= (ready_phase % 5 != 0);
      endcase
   end

   // ------------------------------------------------------------------
   // Request and register tasks
   // ------------------------------------------------------------------

   // Send one request; open a random gap, or none, at each burst start.
   task automatic send_request(input logic [1:0] func, input logic [7:0] data);
      int gap_len;
      if (burst_left == 0) begin
         if ($urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(100, 200);
            gap_len    = 0;
         end else begin
            burst_left = $urandom_range(1, 30);
            gap_len    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 6);
         end
         if (gap_len != 0) begin
            req_valid <= 1'b0;
            repeat (gap_len) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_func     <= func;
      req_mem_data <= data;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_channel_step(func, data));
   endtask

   // Hold off new requests until every result is in, then let the pipe settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input dmsc_pkg::dmsc_reg_type idx,
                                 input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 5'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         dmsc_pkg::REG_PERIOD_RELOAD:  chan_cfg.period_reload  = value[9:0];
         dmsc_pkg::REG_LOOP_MODE:      chan_cfg.loop_mode      = value[0];
         dmsc_pkg::REG_IRQ_ENABLE:     chan_cfg.irq_enable     = value[0];
         dmsc_pkg::REG_SAMPLE_ADDRESS: chan_cfg.sample_address = value[7:0];
         dmsc_pkg::REG_SAMPLE_LENGTH:  chan_cfg.sample_length  = value[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Read a register back and compare it with the value last written.
   task automatic check_register(input dmsc_pkg::dmsc_reg_type idx,
                                 input logic [31:0] exp_v);
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= 5'(idx) << 2;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (got !== exp_v) begin
         $display("%0t: register %s readback, expected %0h actual %0h",
                  $time, idx.name(), exp_v, got);
         error_count++;
      end
      @(posedge clock);
   endtask

   task automatic write_all_registers(input logic [9:0] period, input logic loop_on,
                                      input logic irq_on, input logic [7:0] addr,
                                      input logic [7:0] len);
      write_register(dmsc_pkg::REG_PERIOD_RELOAD, 32'(period));
      write_register(dmsc_pkg::REG_LOOP_MODE, 32'(loop_on));
      write_register(dmsc_pkg::REG_IRQ_ENABLE, 32'(irq_on));
      write_register(dmsc_pkg::REG_SAMPLE_ADDRESS, 32'(addr));
      write_register(dmsc_pkg::REG_SAMPLE_LENGTH, 32'(len));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Write every register at its extremes and read each one back.
   task automatic test_register_access();
      write_all_registers(10'd1023, 1'b1, 1'b1, 8'd255, 8'd255);
      check_register(dmsc_pkg::REG_PERIOD_RELOAD, 32'd1023);
      check_register(dmsc_pkg::REG_LOOP_MODE, 32'd1);
      check_register(dmsc_pkg::REG_IRQ_ENABLE, 32'd1);
      check_register(dmsc_pkg::REG_SAMPLE_ADDRESS, 32'd255);
      check_register(dmsc_pkg::REG_SAMPLE_LENGTH, 32'd255);
      write_all_registers(10'd3, 1'b0, 1'b0, 8'd0, 8'd1);
      check_register(dmsc_pkg::REG_PERIOD_RELOAD, 32'd3);
      check_register(dmsc_pkg::REG_LOOP_MODE, 32'd0);
      check_register(dmsc_pkg::REG_IRQ_ENABLE, 32'd0);
      check_register(dmsc_pkg::REG_SAMPLE_ADDRESS, 32'd0);
      check_register(dmsc_pkg::REG_SAMPLE_LENGTH, 32'd1);
   endtask

   // Unused code, stop while idle, start, start while playing, a full fetch,
   // then a stop while the fetched byte waits in the buffer.
   task automatic test_request_codes();
      send_request(FUNC_UNUSED, 8'hFF);
      send_request(dmsc_pkg::FUNC_STOP, 8'h00);
      send_request(dmsc_pkg::FUNC_START, 8'h00);
      send_request(dmsc_pkg::FUNC_START, 8'h00);
      repeat (4) send_request(dmsc_pkg::FUNC_TICK, 8'hA5);
      repeat (22) send_request(dmsc_pkg::FUNC_TICK, 8'hFF);
      send_request(dmsc_pkg::FUNC_STOP, 8'h00);
      send_request(dmsc_pkg::FUNC_TICK, 8'h00);
      wait_drained();
   endtask

   // One-byte sample: sticky interrupt without loop, then restart with loop.
   task automatic test_sample_end();
      write_register(dmsc_pkg::REG_SAMPLE_LENGTH, 32'd0);
      write_register(dmsc_pkg::REG_IRQ_ENABLE, 32'd1);
      send_request(dmsc_pkg::FUNC_START, 8'h00);
      repeat (6) send_request(dmsc_pkg::FUNC_TICK, 8'h5A);
      wait_drained();
      write_register(dmsc_pkg::REG_LOOP_MODE, 32'd1);
      send_request(dmsc_pkg::FUNC_START, 8'h00);
      repeat (6) send_request(dmsc_pkg::FUNC_TICK, 8'hC3);
      wait_drained();
   endtask

   // Random settings per phase, each phase a start followed mostly by ticks
   // with some stops, restarts and unused codes mixed in.
   task automatic test_random_playback();
      logic [9:0] period;
      logic [7:0] len;
      logic [7:0] addr;
      int         count;
      int         pick;
      for (int phase = 0; phase < 8; phase++) begin
         wait_drained();
         case (phase)
            0: period = 10'd1023;
            1: period = 10'd0;
            default: period = ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                                          : 10'($urandom_range(1, 6));
         endcase
         len  = ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 3));
         addr = ($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom);
         write_all_registers(period, 1'($urandom), 1'($urandom), addr, len);
         send_request(dmsc_pkg::FUNC_START, 8'($urandom));
         count = $urandom_range(35, 45);
         for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
               send_request(dmsc_pkg::FUNC_TICK, 8'($urandom));
            end else if (pick < 93) begin
               send_request(dmsc_pkg::FUNC_STOP, 8'($urandom));
            end else if (pick < 97) begin
               send_request(dmsc_pkg::FUNC_START, 8'($urandom));
            end else begin
               send_request(FUNC_UNUSED, 8'($urandom));
            end
         end
      end
      wait_drained();
   endtask

   // Drive the level into the top rail and then the bottom rail, while the
   // fetch address runs from the top of the space past its wrap.
   task automatic test_level_limits();
      logic [7:0] noise;
      send_request(dmsc_pkg::FUNC_STOP, 8'h00);
      wait_drained();
      write_all_registers(10'd1, 1'b1, 1'b0, 8'd255, 8'd4);
      send_request(dmsc_pkg::FUNC_START, 8'h00);
      for (int n = 0; n < 280; n++) begin
         noise = ($urandom_range(0, 15) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
         send_request(dmsc_pkg::FUNC_TICK, 8'hFF ^ noise);
      end
      for (int n = 0; n < 280; n++) begin
         noise = ($urandom_range(0, 15) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
         send_request(dmsc_pkg::FUNC_TICK, noise);
      end
      wait_drained();
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      chan_cfg               = '0;
      chan_cfg.period_reload = dmsc_pkg::PERIOD_RESET;
      chan_state              = '0;
      chan_state.period_count = dmsc_pkg::PERIOD_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_access();
      test_request_codes();
      test_sample_end();
      test_random_playback();
      test_level_limits();

      wait_drained();
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Bound the run well past the slowest legal schedule.
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

/* files.f */
rtl/dmsc_pkg.sv
rtl/dmsc_step.sv
rtl/delta_modulation_sample_channel.sv
test/delta_modulation_sample_channel_test.sv
